// ===== rtl/sorted_stop_set_assert.svh =====
// Assertion macros for the sorted stop set, clocked on clk, disabled in reset.
`ifndef SORTED_STOP_SET_ASSERT_SVH
`define SORTED_STOP_SET_ASSERT_SVH

// Same-cycle implication.
`define SSS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sss_pkg.sv =====
// Shared types and codes for the sorted stop set.
`timescale 1ns / 1ps

package sss_pkg;

	// Operation codes carried in s_tuser
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_SPAN   = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;
	localparam logic [1:0] MODE_QUERY  = 2'd3;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_DECIDE,
		ST_APPEND1,
		ST_DONE
	} sss_state_t;

	// Accumulator control
	typedef struct packed {
		logic clr;  // start a new scan
		logic en;   // read data valid, fold it in
	} sss_acc_ctl_t;

endpackage

// ===== rtl/sss_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sss_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/sss_accum.sv =====
// Scan accumulator: folds stored values into predecessor, successor, count and hits.
`timescale 1ns / 1ps

module sss_accum
	import sss_pkg::*;
#(
	parameter int POS_W = 16,
	parameter int CNT_W = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sss_acc_ctl_t      ctl,
	input  logic [POS_W-1:0]  pos,
	input  logic [POS_W-1:0]  endp,
	input  logic [POS_W-1:0]  value,
	output logic [POS_W-1:0]  previous_stop,
	output logic [POS_W-1:0]  next_stop,
	output logic [CNT_W-1:0]  range_count,
	output logic              present,
	output logic              end_hit
);

	logic [POS_W-1:0] prev_q, next_q;
	logic             prev_hit_q, next_hit_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pres_q, end_hit_q;

	logic take_prev, take_next, in_range;

	// compares against the current value
	always_comb begin
		take_prev = (value < pos) && (!prev_hit_q || (value > prev_q));
		take_next = (value > pos) && (!next_hit_q || (value < next_q));
		in_range  = (value > pos) && (value <= endp);
	end

	// flags and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_hit_q <= 1'b0;
			next_hit_q <= 1'b0;
			cnt_q      <= '0;
			pres_q     <= 1'b0;
			end_hit_q  <= 1'b0;
		end else if (ctl.clr) begin
			prev_hit_q <= 1'b0;
			next_hit_q <= 1'b0;
			cnt_q      <= '0;
			pres_q     <= 1'b0;
			end_hit_q  <= 1'b0;
		end else if (ctl.en) begin
			if (take_prev) prev_hit_q <= 1'b1;
			if (take_next) next_hit_q <= 1'b1;
			if (in_range) cnt_q <= cnt_q + CNT_W'(1);
			if (value == pos) pres_q <= 1'b1;
			if (value == endp) end_hit_q <= 1'b1;
		end
	end

	// best candidates so far
	always_ff @(posedge clk) begin
		if (ctl.en && !ctl.clr) begin
			if (take_prev) prev_q <= value;
			if (take_next) next_q <= value;
		end
	end

	assign previous_stop = prev_hit_q ? prev_q : pos;
	assign next_stop     = next_hit_q ? next_q : pos;
	assign range_count   = cnt_q;
	assign present       = pres_q;
	assign end_hit       = end_hit_q;

endmodule

// ===== rtl/sorted_stop_set.sv =====
// Sorted stop set: duplicate-free set of positions with insert, span insert, clear, query.
// Clear goes straight to the result; insert, span insert and query scan all stored entries,
// then decide, and span insert then appends its end; the scan is skipped when the set is empty.
// A scan reads the store RAM once, one entry per cycle on its single read port.
// Items are taken one at a time, only in idle; an item may enter while the last result waits.
// Reset (arst_n low, async): set empty, no item in flight, no result pending.
`timescale 1ns / 1ps
`include "sorted_stop_set_assert.svh"

module sorted_stop_set
	import sss_pkg::*;
#(
	parameter int MAX_VERTICES  = 64,
	parameter int POSITION_BITS = 16,
	localparam int IN_W  = ((2 * POSITION_BITS + 7) / 8) * 8,
	localparam int CNT_W = $clog2(MAX_VERTICES + 1),
	localparam int OUT_W = ((2 * POSITION_BITS + CNT_W + 2 + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [P-1:0] position, [2P-1:P] end_position, zero fill
	input  logic [IN_W-1:0]     s_tdata,
	// [1:0] mode
	input  logic [1:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [P-1:0] previous_stop, [2P-1:P] next_stop, then range_count, present,
	// overflow, zero fill
	output logic [OUT_W-1:0]    m_tdata
);

	localparam int P       = POSITION_BITS;
	localparam int AW      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int OUT_RAW = 2 * P + CNT_W + 2;

	sss_state_t       state_q, state_d;
	logic [1:0]       mode_q;
	logic [P-1:0]     pos_q, endp_q;
	logic [CNT_W-1:0] count_q;
	logic [AW-1:0]    rd_idx_q;
	logic             rd_vld_q;
	logic             ovf_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic             accept, full, last_rd, load;
	logic             rd_en, we, cnt_inc, ovf_set;
	logic [AW-1:0]    waddr;
	logic [P-1:0]     wdata, rdata;
	sss_acc_ctl_t     acc_ctl;
	logic [P-1:0]     acc_prev, acc_next;
	logic [CNT_W-1:0] acc_cnt;
	logic             acc_pres, acc_end_hit;
	logic [OUT_RAW-1:0] result;

	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(MAX_VERTICES));
	assign last_rd  = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q);
	assign load     = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// store memory
	sss_ram #(
		.DEPTH(MAX_VERTICES),
		.WIDTH(P),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	// scan accumulator
	assign acc_ctl.clr = accept;
	assign acc_ctl.en  = rd_vld_q;

	sss_accum #(
		.POS_W(P),
		.CNT_W(CNT_W)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (acc_ctl),
		.pos          (pos_q),
		.endp         (endp_q),
		.value        (rdata),
		.previous_stop(acc_prev),
		.next_stop    (acc_next),
		.range_count  (acc_cnt),
		.present      (acc_pres),
		.end_hit      (acc_end_hit)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath strobes
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		we      = 1'b0;
		waddr   = count_q[AW-1:0];
		wdata   = pos_q;
		cnt_inc = 1'b0;
		ovf_set = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == MODE_CLEAR) begin
						state_d = ST_DONE;
					end else if (count_q == '0) begin
						state_d = ST_DECIDE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (last_rd) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if ((mode_q inside {MODE_INSERT, MODE_SPAN}) && !acc_pres) begin
					if (full) begin
						ovf_set = 1'b1;
					end else begin
						we      = 1'b1;
						wdata   = pos_q;
						cnt_inc = 1'b1;
					end
				end
				state_d = (mode_q == MODE_SPAN) ? ST_APPEND1 : ST_DONE;
			end
			ST_APPEND1: begin
				// span end, unless already stored or equal to the start
				if (!acc_end_hit && (endp_q != pos_q)) begin
					if (full) begin
						ovf_set = 1'b1;
					end else begin
						we      = 1'b1;
						wdata   = endp_q;
						cnt_inc = 1'b1;
					end
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			rd_idx_q   <= '0;
			rd_vld_q   <= 1'b0;
			ovf_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_q <= rd_en;
			if (accept) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
			if (accept && s_tuser == MODE_CLEAR) begin
				count_q <= '0;
			end else if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (accept) begin
				ovf_q <= 1'b0;
			end else if (ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (state_q == ST_DONE && load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// item payload latched at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_tuser;
			pos_q  <= s_tdata[P-1:0];
			endp_q <= s_tdata[2*P-1:P];
		end
	end

	// result packing
	always_comb begin
		if (mode_q == MODE_QUERY) begin
			result = {1'b0, acc_pres, acc_cnt, acc_next, acc_prev};
		end else begin
			result = {ovf_q, 1'b0, {CNT_W{1'b0}}, {P{1'b0}}, {P{1'b0}}};
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && load) begin
			m_tdata_q <= OUT_W'(result);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	`SSS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_VERTICES), "entry count above capacity")
	`SSS_ASSERT_IMP(a_no_write_full, we, !full, "store written while full")
	`SSS_ASSERT_IMP(a_no_rw_overlap, we, !rd_en && !rd_vld_q, "store written during scan")
	`SSS_ASSERT_NXT(a_clear_empties, accept && s_tuser == MODE_CLEAR, count_q == '0, "clear left entries")

endmodule
